@@ rtl/core/blpr_pkg.sv @@
package blpr_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RDATA_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LENGTH_W = 5;

  // packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // default sizing
  localparam int unsigned DEF_CAPACITY      = 16;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // decoded operation, handed from the control decode to every cell
  typedef struct packed {
    logic    push_ok;
    logic    pop_ok;
    logic    rem_ok;
    status_t status;
  } op_t;

endpackage

@@ rtl/core/blpr_ctrl.sv @@
module blpr_ctrl #(
  parameter int unsigned CAPACITY = blpr_pkg::DEF_CAPACITY,
  parameter int unsigned CMPW     = 5
) (
  input  logic                    accept,
  input  logic [blpr_pkg::ACTION_W-1:0] action,
  input  logic [CMPW-1:0]         pos,
  input  logic [CMPW-1:0]         count,
  output blpr_pkg::op_t           op
);

  logic is_empty;
  logic is_full;

  assign is_empty = (count == '0);
  assign is_full  = (count >= CMPW'(CAPACITY));

  always_comb begin
    op = '{push_ok: 1'b0, pop_ok: 1'b0, rem_ok: 1'b0, status: blpr_pkg::ST_OK};
    unique case (blpr_pkg::act_t'(action))
      blpr_pkg::ACT_PUSH: begin
        if (is_full) begin
          op.status = blpr_pkg::ST_FULL;
        end else begin
          op.push_ok = accept;
        end
      end
      blpr_pkg::ACT_POP: begin
        if (is_empty) begin
          op.status = blpr_pkg::ST_EMPTY;
        end else begin
          op.pop_ok = accept;
        end
      end
      blpr_pkg::ACT_REMOVE: begin
        // empty is reported ahead of a bad index
        priority if (is_empty) begin
          op.status = blpr_pkg::ST_EMPTY;
        end else if (pos >= count) begin
          op.status = blpr_pkg::ST_RANGE;
        end else begin
          op.rem_ok = accept;
        end
      end
      default: begin
        // unused code: no change, ok status
        op.status = blpr_pkg::ST_OK;
      end
    endcase
  end

endmodule

@@ rtl/core/blpr_cell.sv @@
module blpr_cell #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned CMPW          = 5,
  parameter int unsigned ELEMENT_WIDTH = blpr_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  blpr_pkg::op_t            op,
  input  logic [CMPW-1:0]          count,
  input  logic [CMPW-1:0]          pos,
  input  logic [ELEMENT_WIDTH-1:0] push_data,
  input  logic [ELEMENT_WIDTH-1:0] nbr_data,
  output logic [ELEMENT_WIDTH-1:0] data_q
);

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;
  logic [CMPW-1:0]          last;

  assign last = count - CMPW'(1);

  always_comb begin
    data_nxt = data_r;
    priority if (op.push_ok && (MY_IDX == count)) begin
      data_nxt = push_data;
    end else if ((op.pop_ok || op.rem_ok) && (MY_IDX == last)) begin
      data_nxt = '0;
    end else if (op.rem_ok && (MY_IDX >= pos) && (MY_IDX < last)) begin
      data_nxt = nbr_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_q = data_r;

endmodule

@@ rtl/core/bounded_list_push_pop_remove_at_core.sv @@
// bounded list with push, pop and remove-at
//
// input channel in_*: one transaction is one operation (push, pop, remove-at).
// output channel out_*: exactly one result transaction per input transaction,
// carrying the removed element (zero if none), a status code and the list
// length after the operation. status: ok, empty, index out of range, full.
// a failed operation leaves the list untouched.
//
// the list lives in a row of CAPACITY cells, one element per cell; a
// remove-at shifts every later cell one place toward the front together,
// each cell loading from its upper neighbor.
// the result is registered and valid in the cycle after acceptance.
// throughput: one transaction per cycle while out_tready stays high; the
// single output register sets this figure.
// stall: with a result pending and out_tready low, in_tready drops and
// nothing is lost; the result holds until taken.
// reset: synchronous, active low; all cells clear to zero, length zero,
// no result pending.
module bounded_list_push_pop_remove_at_core #(
  parameter int unsigned CAPACITY      = blpr_pkg::DEF_CAPACITY,
  parameter int unsigned ELEMENT_WIDTH = blpr_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] action, [5:2] index, [37:6] value, [39:38] zero
  input  logic [blpr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] read_data, [33:32] status, [38:34] length, [39] zero
  output logic [blpr_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // count register width and a common compare width for index and length
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > blpr_pkg::LENGTH_W) ? CW : blpr_pkg::LENGTH_W;
  // common width for value in and element out
  localparam int unsigned XW   = (ELEMENT_WIDTH > blpr_pkg::VALUE_W) ?
                                 ELEMENT_WIDTH : blpr_pkg::VALUE_W;

  // input fields
  logic [blpr_pkg::ACTION_W-1:0] in_action;
  logic [blpr_pkg::INDEX_W-1:0]  in_index;
  logic [blpr_pkg::VALUE_W-1:0]  in_value;

  assign in_action = in_tdata[1:0];
  assign in_index  = in_tdata[5:2];
  assign in_value  = in_tdata[37:6];

  logic accept;
  assign accept = in_tvalid && in_tready;

  // list length
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [CMPW-1:0] count_x;
  logic [CMPW-1:0] pos_x;

  assign count_x = CMPW'(count_r);
  assign pos_x   = CMPW'(in_index);

  blpr_pkg::op_t op;

  blpr_ctrl #(
    .CAPACITY (CAPACITY),
    .CMPW     (CMPW)
  ) u_ctrl (
    .accept (accept),
    .action (in_action),
    .pos    (pos_x),
    .count  (count_x),
    .op     (op)
  );

  // push value zero-extended or trimmed to the element width
  logic [XW-1:0]            value_x;
  logic [ELEMENT_WIDTH-1:0] push_elem;

  assign value_x   = XW'(in_value);
  assign push_elem = value_x[ELEMENT_WIDTH-1:0];

  // cell row; the last cell shifts in zero
  logic [ELEMENT_WIDTH-1:0] cell_q [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_nbr [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_tail
      assign cell_nbr[g] = '0;
    end else begin : g_link
      assign cell_nbr[g] = cell_q[g+1];
    end

    blpr_cell #(
      .IDX           (g),
      .CMPW          (CMPW),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .count     (count_x),
      .pos       (pos_x),
      .push_data (push_elem),
      .nbr_data  (cell_nbr[g]),
      .data_q    (cell_q[g])
    );
  end

  // one read port: pop reads the tail, remove-at reads the index
  logic [CMPW-1:0]          rd_sel;
  logic [AW-1:0]            rd_addr;
  logic [ELEMENT_WIDTH-1:0] rd_elem;
  logic [XW-1:0]            rd_x;
  logic [blpr_pkg::RDATA_W-1:0] rd_data;

  assign rd_sel  = op.pop_ok ? (count_x - CMPW'(1)) : pos_x;
  assign rd_addr = rd_sel[AW-1:0];
  assign rd_elem = cell_q[rd_addr];
  assign rd_x    = XW'(rd_elem);
  assign rd_data = (op.pop_ok || op.rem_ok) ? rd_x[blpr_pkg::RDATA_W-1:0] : '0;

  always_comb begin
    count_nxt = count_r;
    priority if (op.push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (op.pop_ok || op.rem_ok) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // result register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [blpr_pkg::RDATA_W-1:0]  out_rdata_r;
  blpr_pkg::status_t             out_status_r;
  logic [blpr_pkg::LENGTH_W-1:0] out_length_r;
  logic [CMPW-1:0]               len_x;

  assign len_x         = CMPW'(count_nxt);
  assign in_tready     = !out_valid_r || out_tready;
  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rdata_r  <= rd_data;
      out_status_r <= op.status;
      out_length_r <= len_x[blpr_pkg::LENGTH_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_length_r, out_status_r, out_rdata_r};

  // length never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_x <= CMPW'(CAPACITY))
    else $error("list length above capacity");

  // failed or unused operations leave the length alone
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !op.push_ok && !op.pop_ok && !op.rem_ok) |=> $stable(count_r))
    else $error("length changed on a failed operation");

  // a successful push grows the list by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op.push_ok) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the list");

  // every accepted operation leaves a result pending
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule
